FILE: design/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
// Used by ilp_scan, ilp_classify and integer_literal_parser; no dependencies.
package ilp_pkg;

    // Type widths in bits
    localparam int INT_BITS  = 32;
    localparam int LONG_BITS = 32;

    // Largest magnitudes per type
    localparam logic [63:0] INT_SMAX  = (64'd1 << (INT_BITS - 1)) - 64'd1;
    localparam logic [63:0] INT_UMAX  = (INT_BITS >= 64) ? {64{1'b1}}
                                      : ((64'd1 << INT_BITS) - 64'd1);
    localparam logic [63:0] LONG_SMAX = (64'd1 << (LONG_BITS - 1)) - 64'd1;
    localparam logic [63:0] LONG_UMAX = (LONG_BITS >= 64) ? {64{1'b1}}
                                      : ((64'd1 << LONG_BITS) - 64'd1);
    localparam logic [63:0] LL_SMAX   = {1'b0, {63{1'b1}}};
    localparam logic [63:0] LL_UMAX   = {64{1'b1}};

    // Radix codes
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_INT       = 3'd0;
    localparam logic [2:0] KIND_UINT      = 3'd1;
    localparam logic [2:0] KIND_LONG      = 3'd2;
    localparam logic [2:0] KIND_ULONG     = 3'd3;
    localparam logic [2:0] KIND_LONGLONG  = 3'd4;
    localparam logic [2:0] KIND_ULONGLONG = 3'd5;
    localparam logic [2:0] KIND_TOO_LARGE = 3'd6;
    localparam logic [2:0] KIND_BAD_DIGIT = 3'd7;

    // Characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [5:0] DIGIT_TEN  = 6'd10;
    localparam logic [5:0] DIGIT_NONE = 6'd36;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
        logic [1:0] base_code;
        logic       unsigned_suffix;
        logic       long_suffix;
    } item_t;

    typedef struct packed {
        logic        negative;
        logic [63:0] magnitude;
        logic [2:0]  kind;
    } result_t;

    // Finished literal handed from scan to classify
    typedef struct packed {
        logic        negative;
        logic [63:0] magnitude;
        logic        uns;
        logic        lng;
        logic        bad;
        logic        too_big;
    } prep_t;

endpackage

FILE: design/ilp_scan.sv
// Per-character literal state: sign, prefix skip, digit accumulate, overflow.
// Depends on ilp_pkg.
module ilp_scan
    import ilp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  go,
    output prep_t prep
);

    logic [63:0] accum_reg, accum_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic        bad_reg, bad_next;
    logic        seen_reg, seen_next;
    logic [1:0]  skip_reg, skip_next;
    logic [1:0]  radix_reg, radix_next;
    logic        uns_reg, uns_next;
    logic        lng_reg, lng_next;

    logic [63:0] acc_cur;
    logic        neg_cur, ovf_cur, bad_cur, seen_cur, sign_hit;
    logic [1:0]  skip_cur;
    logic [5:0]  dval;
    logic [5:0]  base;
    logic [67:0] prod, sum;

    always_comb
    begin
        // Digit value
        if (item.ch inside {[CH_ZERO:CH_NINE]})
            dval = 6'(item.ch - CH_ZERO);
        else if (item.ch inside {[CH_LA:CH_LZ]})
            dval = 6'(item.ch - CH_LA) + DIGIT_TEN;
        else if (item.ch inside {[CH_UA:CH_UZ]})
            dval = 6'(item.ch - CH_UA) + DIGIT_TEN;
        else
            dval = DIGIT_NONE;

        radix_next = item.first ? item.base_code       : radix_reg;
        uns_next   = item.first ? item.unsigned_suffix : uns_reg;
        lng_next   = item.first ? item.long_suffix     : lng_reg;

        case (radix_next)
            RADIX_BIN: begin base = 6'd2;  prod = {4'b0, accum_reg} << 1; end
            RADIX_OCT: begin base = 6'd8;  prod = {4'b0, accum_reg} << 3; end
            RADIX_DEC:
            begin
                base = 6'd10;
                prod = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1);
            end
            default:   begin base = 6'd16; prod = {4'b0, accum_reg} << 4; end
        endcase

        // A first character starts from cleared state; prod is unused then
        acc_cur  = item.first ? 64'd0 : accum_reg;
        neg_cur  = item.first ? (item.ch == CH_MINUS) : neg_reg;
        ovf_cur  = item.first ? 1'b0 : ovf_reg;
        bad_cur  = item.first ? 1'b0 : bad_reg;
        seen_cur = item.first ? 1'b0 : seen_reg;
        if (item.first)
            skip_cur = (item.base_code == RADIX_BIN || item.base_code == RADIX_HEX)
                       ? 2'd2 : 2'd0;
        else
            skip_cur = skip_reg;
        sign_hit = item.first && (item.ch == CH_MINUS || item.ch == CH_PLUS);

        if (item.first)
            sum = {62'd0, dval};
        else
            sum = prod + {62'd0, dval};

        accum_next = acc_cur;
        ovf_next   = ovf_cur;
        bad_next   = bad_cur;
        seen_next  = seen_cur;
        skip_next  = skip_cur;
        neg_next   = neg_cur;

        if (!sign_hit)
        begin
            if (skip_cur != 2'd0)
                skip_next = skip_cur - 2'd1;
            else if (!ovf_cur && !bad_cur)
            begin
                if (dval >= base)
                    bad_next = 1'b1;
                else if (sum[67:64] != 4'd0)
                    ovf_next = 1'b1;
                else
                begin
                    accum_next = sum[63:0];
                    seen_next  = 1'b1;
                end
            end
        end

        prep.negative  = neg_next;
        prep.magnitude = accum_next;
        prep.uns       = uns_next;
        prep.lng       = lng_next;
        prep.bad       = bad_next || !seen_next;
        prep.too_big   = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            skip_reg  <= '0;
            radix_reg <= RADIX_BIN;
            uns_reg   <= 1'b0;
            lng_reg   <= 1'b0;
        end
        else if (go)
        begin
            radix_reg <= radix_next;
            uns_reg   <= uns_next;
            lng_reg   <= lng_next;
            if (item.last)
            begin
                // drop literal state, keep radix and suffix
                accum_reg <= '0;
                neg_reg   <= 1'b0;
                ovf_reg   <= 1'b0;
                bad_reg   <= 1'b0;
                seen_reg  <= 1'b0;
                skip_reg  <= '0;
            end
            else
            begin
                accum_reg <= accum_next;
                neg_reg   <= neg_next;
                ovf_reg   <= ovf_next;
                bad_reg   <= bad_next;
                seen_reg  <= seen_next;
                skip_reg  <= skip_next;
            end
        end
    end

endmodule

FILE: design/ilp_classify.sv
// Picks the first type that holds a finished literal, or an error kind.
// Depends on ilp_pkg.
module ilp_classify
    import ilp_pkg::*;
(
    input  prep_t   prep,
    output result_t res
);

    function automatic logic fits_s(input logic neg, input logic [63:0] mag,
                                    input logic [63:0] smax);
        fits_s = neg ? (mag <= smax + 64'd1) : (mag <= smax);
    endfunction

    function automatic logic fits_u(input logic neg, input logic [63:0] mag,
                                    input logic [63:0] umax);
        fits_u = !neg && (mag <= umax);
    endfunction

    logic [2:0] kind;

    always_comb
    begin
        if (prep.bad)
            kind = KIND_BAD_DIGIT;
        else if (prep.too_big)
            kind = KIND_TOO_LARGE;
        else if (!prep.uns && !prep.lng && fits_s(prep.negative, prep.magnitude, INT_SMAX))
            kind = KIND_INT;
        else if (!prep.lng && fits_u(prep.negative, prep.magnitude, INT_UMAX))
            kind = KIND_UINT;
        else if (!prep.uns && fits_s(prep.negative, prep.magnitude, LONG_SMAX))
            kind = KIND_LONG;
        else if (fits_u(prep.negative, prep.magnitude, LONG_UMAX))
            kind = KIND_ULONG;
        else if (!prep.uns && fits_s(prep.negative, prep.magnitude, LL_SMAX))
            kind = KIND_LONGLONG;
        else if (fits_u(prep.negative, prep.magnitude, LL_UMAX))
            kind = KIND_ULONGLONG;
        else
            kind = KIND_TOO_LARGE;

        res.negative  = prep.negative;
        res.kind      = kind;
        res.magnitude = (kind == KIND_TOO_LARGE || kind == KIND_BAD_DIGIT)
                        ? 64'd0 : prep.magnitude;
    end

endmodule

FILE: design/integer_literal_parser.sv
// Integer literal parser: character stream in, one classified result per literal.
// Depends on ilp_pkg, ilp_scan and ilp_classify.
//
// Usage: in_data carries one character per transfer on in_valid/in_ready, with
// first on the opening character (radix and suffix flags sampled there) and
// last on the closing one. Characters that are not last give no result. On a
// last character one result leaves on out_valid/out_ready: the sign, the
// magnitude and the kind (int .. ulonglong, too large, bad digit).
// Path: a last character's result is registered in turn in the input register,
// the scan stage (prep register) and the output register.
// Throughput: one character per cycle unless a last character is held; the
// 64-bit multiply-add with its overflow check in the scan stage sets that figure.
// When the receiver stalls, the output and the prep register hold their
// results; non-last characters keep flowing and a last character waits in the
// input register until the prep register frees.
// Reset clears all valid flags and the literal state; radix resets to binary.
module integer_literal_parser
    import ilp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    item_t   item_reg;
    logic    item_valid_reg;
    prep_t   prep_reg;
    logic    prep_valid_reg, prep_valid_next;
    result_t out_reg;
    logic    out_valid_reg;

    prep_t   prep_comb;
    result_t res_comb;
    logic    out_free, prep_free, item_go;

    assign out_free  = !out_valid_reg || out_ready;
    assign prep_free = !prep_valid_reg || out_free;
    assign item_go   = item_valid_reg && (!item_reg.last || prep_free);
    assign in_ready  = !item_valid_reg || item_go;

    ilp_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_reg),
        .go    (item_go),
        .prep  (prep_comb)
    );

    ilp_classify u_classify (
        .prep (prep_reg),
        .res  (res_comb)
    );

    always_comb
    begin
        if (item_go && item_reg.last)
            prep_valid_next = 1'b1;
        else if (out_free)
            prep_valid_next = 1'b0;
        else
            prep_valid_next = prep_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            prep_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            prep_valid_reg <= prep_valid_next;
            if (out_free)
                out_valid_reg <= prep_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (item_go && item_reg.last)
            prep_reg <= prep_comb;
        if (out_free && prep_valid_reg)
            out_reg <= res_comb;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Backpressure only ever comes from a held last character
    a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid_reg && item_reg.last && prep_valid_reg && !out_free)
        else $error("input stalled without a blocked last character");

    // A pending prep result is never overwritten or lost under a stall
    a_prep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid_reg && !out_free |=> prep_valid_reg && $stable(prep_reg))
        else $error("prep result lost under output stall");

    // Error kinds carry zero magnitude
    a_err_mag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_TOO_LARGE || out_data.kind == KIND_BAD_DIGIT)
        |-> out_data.magnitude == 64'd0)
        else $error("error result with nonzero magnitude");

    // An int result stays within the int range
    a_int_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_INT
        |-> out_data.magnitude <= INT_SMAX + {63'd0, out_data.negative})
        else $error("int result out of range");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for integer_literal_parser: streams directed and random literals, predicts
// each result in a cycle-free model of the parser and checks every output transfer.
// Depends on ilp_pkg and the integer_literal_parser RTL.
module tb_top
    import ilp_pkg::*;
();

    localparam int          STALL_LIMIT = 5000;
    localparam int          HOLD_CYCLES = 200;
    localparam int          TAIL_CYCLES = 10;
    localparam logic [7:0]  CH_LX       = 8'h78;
    localparam logic [7:0]  CH_UX       = 8'h58;
    localparam logic [7:0]  CH_LB       = 8'h62;
    localparam logic [7:0]  CH_UB       = 8'h42;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_ready;
    item_t   in_data   = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    result_t out_data;

    item_t   pending[$];
    result_t expected_results[$];
    logic [7:0] lit_text[$];
    int      send_idle_pct = 29;
    int      recv_idle_pct = 54;
    int      phase         = 0;
    int      item_count    = 0;
    int      mismatches    = 0;
    int      stall_cycles  = 0;
    int      hold_left     = 0;
    logic    hold_done     = 1'b0;
    logic [1:0] queued_radix = RADIX_BIN;
    result_t drv_res;
    result_t want;

    // parser state as the predictor sees it
    logic [63:0] lit_accum = '0;
    logic        lit_neg   = 1'b0;
    logic        lit_ovf   = 1'b0;
    logic        lit_bad   = 1'b0;
    logic        lit_digit = 1'b0;
    logic [1:0]  lit_skip  = '0;
    logic [1:0]  lit_radix = RADIX_BIN;
    logic        lit_uns   = 1'b0;
    logic        lit_lng   = 1'b0;

    integer_literal_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] radix_value(input logic [1:0] code);
        case (code)
            RADIX_BIN: return 64'd2;
            RADIX_OCT: return 64'd8;
            RADIX_DEC: return 64'd10;
            default:   return 64'd16;
        endcase
    endfunction

    function automatic logic [63:0] digit_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 64'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LZ) return 64'(DIGIT_TEN) + 64'(c - CH_LA);
        if (c >= CH_UA && c <= CH_UZ) return 64'(DIGIT_TEN) + 64'(c - CH_UA);
        return 64'(DIGIT_NONE);
    endfunction

    function automatic logic fits_type(input logic neg, input logic [63:0] mag,
                                       input int nbits, input logic is_signed);
        logic [63:0] top;
        top = (nbits >= 64) ? {64{1'b1}} : ((64'd1 << nbits) - 64'd1);
        if (!is_signed) return !neg && mag <= top;
        top = top >> 1;
        if (!neg) return mag <= top;
        return mag <= top + 64'd1;
    endfunction

    // first type in C promotion order that the suffixes allow and the value fits
    function automatic logic [2:0] type_kind(input logic neg, input logic [63:0] mag,
                                             input logic uns, input logic lng);
        if (!uns && !lng && fits_type(neg, mag, INT_BITS, 1'b1)) return KIND_INT;
        if (!lng && fits_type(neg, mag, INT_BITS, 1'b0)) return KIND_UINT;
        if (!uns && fits_type(neg, mag, LONG_BITS, 1'b1)) return KIND_LONG;
        if (fits_type(neg, mag, LONG_BITS, 1'b0)) return KIND_ULONG;
        if (!uns && fits_type(neg, mag, 64, 1'b1)) return KIND_LONGLONG;
        if (fits_type(neg, mag, 64, 1'b0)) return KIND_ULONGLONG;
        return KIND_TOO_LARGE;
    endfunction

    function automatic void clear_literal();
        lit_accum = '0;
        lit_neg   = 1'b0;
        lit_ovf   = 1'b0;
        lit_bad   = 1'b0;
        lit_digit = 1'b0;
        lit_skip  = '0;
    endfunction

    // advance the parser by one character; returns 1 when a result is due
    function automatic logic parse_char(input item_t it, output result_t res);
        logic        consumed;
        logic [63:0] rdx;
        logic [63:0] dval;
        consumed = 1'b0;
        res      = '0;
        if (it.first)
        begin
            clear_literal();
            lit_radix = it.base_code;
            lit_uns   = it.unsigned_suffix;
            lit_lng   = it.long_suffix;
            lit_skip  = (it.base_code == RADIX_BIN || it.base_code == RADIX_HEX) ? 2'd2 : 2'd0;
            if (it.ch == CH_MINUS || it.ch == CH_PLUS)
            begin
                lit_neg  = (it.ch == CH_MINUS);
                consumed = 1'b1;
            end
        end
        if (!consumed)
        begin
            if (lit_skip != 2'd0)
                lit_skip = lit_skip - 2'd1;
            else if (!lit_ovf && !lit_bad)
            begin
                rdx  = radix_value(lit_radix);
                dval = digit_of(it.ch);
                if (dval >= rdx)
                    lit_bad = 1'b1;
                else if (lit_accum > ({64{1'b1}} - dval) / rdx)
                    lit_ovf = 1'b1;
                else
                begin
                    lit_accum = lit_accum * rdx + dval;
                    lit_digit = 1'b1;
                end
            end
        end
        if (!it.last) return 1'b0;
        res.negative = lit_neg;
        if (lit_bad || !lit_digit) res.kind = KIND_BAD_DIGIT;
        else if (lit_ovf) res.kind = KIND_TOO_LARGE;
        else res.kind = type_kind(lit_neg, lit_accum, lit_uns, lit_lng);
        res.magnitude = (res.kind == KIND_TOO_LARGE || res.kind == KIND_BAD_DIGIT)
                        ? 64'd0 : lit_accum;
        clear_literal();
        return 1'b1;
    endfunction

    // queue the characters in lit_text as one literal
    task automatic add_literal(input logic [1:0] radix, input logic uns, input logic lng,
                               input logic use_first, input logic use_last);
        item_t it;
        if (use_first && lit_text.size() != 0)
            queued_radix = radix;
        foreach (lit_text[i])
        begin
            it.ch    = lit_text[i];
            it.first = use_first && (i == 0);
            it.last  = use_last && (i == lit_text.size() - 1);
            if (i == 0)
            begin
                it.base_code       = radix;
                it.unsigned_suffix = uns;
                it.long_suffix     = lng;
            end
            else
            begin
                it.base_code       = 2'($urandom_range(0, 3));
                it.unsigned_suffix = 1'($urandom_range(0, 1));
                it.long_suffix     = 1'($urandom_range(0, 1));
            end
            pending.push_back(it);
            item_count++;
        end
        lit_text.delete();
    endtask

    task automatic add_text(input string s, input logic [1:0] radix, input logic uns,
                            input logic lng, input logic use_first, input logic use_last);
        for (int i = 0; i < s.len(); i++)
            lit_text.push_back(s[i]);
        add_literal(radix, uns, lng, use_first, use_last);
    endtask

    function automatic logic [7:0] digit_char(input logic [63:0] d);
        if (d < 64'(DIGIT_TEN)) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 64'(DIGIT_TEN));
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          k;
        case ($urandom_range(0, 4))
            0: return 64'($urandom_range(0, 1000));
            1: return 64'($urandom);
            2: return {$urandom, $urandom};
            default:
            begin
                case ($urandom_range(0, 5))
                    0: k = 15;
                    1: k = 16;
                    2: k = 31;
                    3: k = 32;
                    4: k = 63;
                    default: k = 64;
                endcase
                v = (k == 64) ? 64'd0 : (64'd1 << k);
                return v + 64'($urandom_range(0, 4)) - 64'd2;
            end
        endcase
    endfunction

    // well-formed literal, optionally broken by one stray character
    task automatic add_number(input logic [1:0] radix, input logic uns, input logic lng,
                              input logic [7:0] sign_ch, input logic [63:0] value,
                              input int extra_digits, input logic use_first,
                              input logic use_last, input logic corrupt);
        logic [7:0]  digs[$];
        logic [63:0] rdx;
        logic [63:0] v;
        int          pos;
        rdx = radix_value(radix);
        v   = value;
        if (use_first)
        begin
            if (sign_ch != 8'd0) lit_text.push_back(sign_ch);
            if (radix == RADIX_BIN || radix == RADIX_HEX)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    lit_text.push_back(8'($urandom_range(0, 255)));
                    lit_text.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    lit_text.push_back(CH_ZERO);
                    if (radix == RADIX_HEX)
                        lit_text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                    else
                        lit_text.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
                end
            end
        end
        do
        begin
            digs.push_front(digit_char(v % rdx));
            v = v / rdx;
        end
        while (v != 64'd0);
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
            digs.push_front(CH_ZERO);
        repeat (extra_digits)
            digs.push_back(digit_char(64'($urandom_range(0, 32'(rdx) - 1))));
        foreach (digs[i])
            lit_text.push_back(digs[i]);
        if (corrupt)
        begin
            pos = $urandom_range(0, lit_text.size() - 1);
            if ($urandom_range(0, 1))
                lit_text[pos] = 8'($urandom_range(0, 255));
            else
                lit_text[pos] = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
        end
        add_literal(radix, uns, lng, use_first, use_last);
    endtask

    // radix of the most recently queued first character
    function automatic logic [1:0] lit_radix_hint();
        return queued_radix;
    endfunction

    task automatic add_random_item();
        item_t       it;
        int          sel;
        logic [1:0]  radix;
        logic [7:0]  sign_ch;
        logic [63:0] value;
        sel   = $urandom_range(0, 99);
        radix = 2'($urandom_range(0, 3));
        value = pick_value();
        case ($urandom_range(0, 3))
            0:       sign_ch = CH_MINUS;
            1:       sign_ch = CH_PLUS;
            default: sign_ch = 8'd0;
        endcase
        if (sel < 8)
        begin
            // raw noise
            it.ch              = 8'($urandom_range(0, 255));
            it.first           = 1'($urandom_range(0, 1));
            it.last            = 1'($urandom_range(0, 1));
            it.base_code       = 2'($urandom_range(0, 3));
            it.unsigned_suffix = 1'($urandom_range(0, 1));
            it.long_suffix     = 1'($urandom_range(0, 1));
            if (it.first)
                queued_radix = it.base_code;
            pending.push_back(it);
            item_count++;
        end
        else if (sel < 12)
            add_number(radix, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sign_ch,
                       value, 0, 1'b1, 1'b1, 1'b1);
        else if (sel < 15)
            // leave the literal open; the next first drops it
            add_number(radix, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sign_ch,
                       value, 0, 1'b1, 1'b0, 1'b0);
        else if (sel < 18)
            // digits with no first continue on the kept radix
            add_number(lit_radix_hint(), 1'b0, 1'b0, 8'd0, value, 0, 1'b0, 1'b1, 1'b0);
        else
            add_number(radix, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sign_ch,
                       value, ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0,
                       1'b1, 1'b1, 1'b0);
    endtask

    task automatic drain_queues();
        while (pending.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // sender: present queued characters, predict each transfer as it is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_valid && parse_char(in_data, drv_res))
                expected_results.push_back(drv_res);
            if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: neg %0b mag %0h kind %0d",
                                 out_data.negative, out_data.magnitude, out_data.kind);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.negative !== want.negative ||
                        out_data.magnitude !== want.magnitude ||
                        out_data.kind !== want.kind)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected neg %0b mag %0h kind %0d,",
                                     want.negative, want.magnitude, want.kind,
                                     " got neg %0b mag %0h kind %0d",
                                     out_data.negative, out_data.magnitude, out_data.kind);
                    end
                end
            end
            // hold off once in the busy phase so the pipeline backs up into the input
            if (phase == 2 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_text("0", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("-0", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("+2147483647", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("-2147483648", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("2147483648", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("2147483648", RADIX_DEC, 1'b0, 1'b1, 1'b1, 1'b1);
        add_text("-2147483649", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("4294967295", RADIX_DEC, 1'b1, 1'b0, 1'b1, 1'b1);
        add_text("18446744073709551615", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("18446744073709551616", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("-9223372036854775808", RADIX_DEC, 1'b0, 1'b1, 1'b1, 1'b1);
        add_text("-5", RADIX_DEC, 1'b1, 1'b0, 1'b1, 1'b1);
        add_text("0b1011", RADIX_BIN, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("0xDeadBEEF", RADIX_HEX, 1'b1, 1'b1, 1'b1, 1'b1);
        add_text("0xffffffffffffffff", RADIX_HEX, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("777", RADIX_OCT, 1'b0, 1'b1, 1'b1, 1'b1);
        add_text("8", RADIX_OCT, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("0b2", RADIX_BIN, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("0xZZ", RADIX_HEX, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("1-2", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("-", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("0x", RADIX_HEX, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("99999999999999999999z", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("z99999999999999999999", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("123", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b0);
        add_text("45", RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b1);
        add_text("77", RADIX_DEC, 1'b0, 1'b0, 1'b0, 1'b1);
        drain_queues();

        while (item_count < 370)
            add_random_item();
        drain_queues();

        send_idle_pct = 54;
        recv_idle_pct = 29;
        phase         = 1;
        while (item_count < 740)
            add_random_item();
        drain_queues();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase         = 2;
        while (item_count < 1100)
            add_random_item();
        drain_queues();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
design/ilp_pkg.sv
design/ilp_scan.sv
design/ilp_classify.sv
design/integer_literal_parser.sv
dv/tb_top.sv
